// ===== rtl/core/per_source_protocol_traffic_counter_defines.svh =====
// ---------------------------------------------------------------------------
// per_source_protocol_traffic_counter_defines
// assertion macros shared by the traffic counter rtl
// ---------------------------------------------------------------------------
`ifndef PER_SOURCE_PROTOCOL_TRAFFIC_COUNTER_DEFINES_SVH
`define PER_SOURCE_PROTOCOL_TRAFFIC_COUNTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pstc_pkg.sv =====
// ---------------------------------------------------------------------------
// pstc_pkg
// shared constants and types of the per-source traffic counter
// ---------------------------------------------------------------------------
package pstc_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int TREE_N  = 1 << IDX_W;
  localparam int CNT_W   = $clog2(IDX_W + 1);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [1:0] ST_IGNORED = 2'd0;
  localparam logic [1:0] ST_HIT     = 2'd1;
  localparam logic [1:0] ST_NEW     = 2'd2;
  localparam logic [1:0] ST_EVICT   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_TREE,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] tcp_byte_cnt;
    logic [63:0] tcp_pkt_cnt;
    logic [63:0] udp_byte_cnt;
    logic [63:0] udp_pkt_cnt;
  } counters_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    counters_t   cnt;
  } entry_t;

  // one leaf of the readout tree: zero unless the cell matched
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    counters_t        cnt;
  } leaf_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp_en;
    logic             shift_en;
    logic [IDX_W-1:0] shift_lim;
    logic [31:0]      key;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] evicted_addr;
    counters_t   cnt;
  } result_t;

endpackage

// ===== rtl/core/pstc_ifs.sv =====
// ---------------------------------------------------------------------------
// pstc_ifs
// valid/ready channels for header words in and result words out
// ---------------------------------------------------------------------------
interface pstc_in_if;
  logic        valid;
  logic        ready;
  logic        header_complete;
  logic [15:0] ether_type;
  logic [31:0] src_addr;
  logic [7:0]  ip_protocol;
  logic [15:0] ip_total_length;

  modport source (
    output valid, header_complete, ether_type, src_addr, ip_protocol, ip_total_length,
    input  ready
  );
  modport sink (
    input  valid, header_complete, ether_type, src_addr, ip_protocol, ip_total_length,
    output ready
  );
endinterface

interface pstc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] evicted_addr;
  logic [63:0] tcp_byte_total;
  logic [63:0] tcp_packet_total;
  logic [63:0] udp_byte_total;
  logic [63:0] udp_packet_total;

  modport source (
    output valid, status, evicted_addr, tcp_byte_total, tcp_packet_total,
           udp_byte_total, udp_packet_total,
    input  ready
  );
  modport sink (
    input  valid, status, evicted_addr, tcp_byte_total, tcp_packet_total,
           udp_byte_total, udp_packet_total,
    output ready
  );
endinterface

// ===== rtl/core/pstc_cell.sv =====
// ---------------------------------------------------------------------------
// pstc_cell
// one entry of the recency-ordered table, shifts in from its upper neighbor
// ---------------------------------------------------------------------------
module pstc_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pstc_pkg::IDX_W-1:0]  cell_idx,
  input  pstc_pkg::cell_ctl_t         ctl,
  input  pstc_pkg::entry_t            prev_entry,
  output pstc_pkg::entry_t            entry,
  output logic                        hit,
  output pstc_pkg::leaf_t             leaf
);
  import pstc_pkg::*;

  entry_t entry_r;
  logic   hit_r;
  logic   take;

  // cells at or above the moved entry slide down one place
  assign take = ctl.shift_en && (cell_idx <= ctl.shift_lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
      hit_r         <= 1'b0;
    end else begin
      if (take) begin
        entry_r <= prev_entry;
      end
      if (ctl.cmp_en) begin
        hit_r <= entry_r.valid && (entry_r.addr == ctl.key);
      end
    end
  end

  assign entry = entry_r;
  assign hit   = hit_r;

  always_comb begin
    leaf = '0;
    if (hit_r) begin
      leaf.found = 1'b1;
      leaf.idx   = cell_idx;
      leaf.cnt   = entry_r.cnt;
    end
  end
endmodule

// ===== rtl/core/pstc_tree.sv =====
// ---------------------------------------------------------------------------
// pstc_tree
// registered or-tree that brings the matching cell's word to the root
// ---------------------------------------------------------------------------
module pstc_tree (
  input  logic             clk,
  input  pstc_pkg::leaf_t  leaves [pstc_pkg::TREE_N],
  output pstc_pkg::leaf_t  root
);
  import pstc_pkg::*;

  // heap layout: node k has children 2k+1 and 2k+2, leaves past TREE_N-2
  leaf_t node_r [TREE_N-1];

  for (genvar k = 0; k < TREE_N - 1; k++) begin : g_node
    leaf_t lhs;
    leaf_t rhs;
    if (2 * k + 1 >= TREE_N - 1) begin : g_leaf_kids
      assign lhs = leaves[2 * k + 1 - (TREE_N - 1)];
      assign rhs = leaves[2 * k + 2 - (TREE_N - 1)];
    end else begin : g_node_kids
      assign lhs = node_r[2 * k + 1];
      assign rhs = node_r[2 * k + 2];
    end
    always_ff @(posedge clk) begin
      node_r[k] <= lhs | rhs;
    end
  end

  assign root = node_r[0];
endmodule

// ===== rtl/core/per_source_protocol_traffic_counter.sv =====
// ---------------------------------------------------------------------------
// per_source_protocol_traffic_counter
// per-source ipv4 tcp/udp packet and byte counters with an exact lru table
// ---------------------------------------------------------------------------
// One header word in gives one result word out. A word with an incomplete
// header or a non-ipv4 ether type goes straight to the hand-over and is
// answered with status 0. Every other word passes these steps in order:
// take the word, compare the key in all cells at once, pass through the
// registered or-tree that brings the matching entry's counters and
// position to the root, update and shift the cell chain, and hand over to
// the output register. A held-off output keeps the
// sequencer waiting in its hand-over cycle with the input closed. The table
// is a chain of cells kept in recency order: cell 0 is the most recently
// used, the last cell is the eviction victim. No clearing pass is needed
// after reset. The next header word is taken in the cycle after the
// previous result lands in the output register.
`include "per_source_protocol_traffic_counter_defines.svh"

module per_source_protocol_traffic_counter (
  input  logic  clk,
  input  logic  rst_n,
  pstc_in_if.sink    in_ch,
  pstc_out_if.source out_ch
);
  import pstc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] lvl_cnt_r;
  logic [31:0]      key_r;
  logic [7:0]       proto_r;
  logic [15:0]      len_r;
  result_t          res_r;
  result_t          out_r;
  logic             out_valid_r;

  // control decoded from the state
  logic      in_acc;
  logic      ignore;
  logic      can_load;
  cell_ctl_t ctl;

  // cell chain
  entry_t      chain   [ENTRIES + 1];
  leaf_t       leaves  [TREE_N];
  logic [ENTRIES-1:0] hit_vec;
  leaf_t       root;
  entry_t      new_entry;
  counters_t   base_cnt;
  logic [1:0]  upd_status;
  logic [31:0] upd_evicted;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign ignore   = !in_ch.header_complete || (in_ch.ether_type != ETHERTYPE_IPV4);
  assign can_load = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) begin
        state_nxt = ignore ? S_DONE : S_CMP;
      end
      S_CMP:  state_nxt = S_TREE;
      S_TREE: if (lvl_cnt_r == CNT_W'(IDX_W - 1)) begin
        state_nxt = S_UPD;
      end
      S_UPD:  state_nxt = S_DONE;
      S_DONE: if (can_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready   = 1'b0;
    ctl.cmp_en    = 1'b0;
    ctl.shift_en  = 1'b0;
    ctl.key       = key_r;
    // a miss shifts the whole chain, a hit only the hit cell and the cells above it
    ctl.shift_lim = root.found ? root.idx : IDX_W'(ENTRIES - 1);
    unique case (state_r)
      S_IDLE:  in_ch.ready  = 1'b1;
      S_CMP:   ctl.cmp_en   = 1'b1;
      S_TREE:  ;
      S_UPD:   ctl.shift_en = 1'b1;
      S_DONE:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CMP) begin
        lvl_cnt_r <= '0;
      end else if (state_r == S_TREE) begin
        lvl_cnt_r <= lvl_cnt_r + 1'b1;
      end
      if (state_r == S_DONE && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // header fields and result word, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r   <= in_ch.src_addr;
      proto_r <= in_ch.ip_protocol;
      len_r   <= in_ch.ip_total_length;
      res_r   <= '0;
    end
    if (state_r == S_UPD) begin
      res_r.status       <= upd_status;
      res_r.evicted_addr <= upd_evicted;
      res_r.cnt          <= new_entry.cnt;
    end
    if (state_r == S_DONE && can_load) begin
      out_r <= res_r;
    end
  end

  // new head entry: old counters on a hit, zero on a miss, then the update
  always_comb begin
    base_cnt = root.found ? root.cnt : '0;
    new_entry       = '0;
    new_entry.valid = 1'b1;
    new_entry.addr  = key_r;
    new_entry.cnt   = base_cnt;
    if (proto_r == PROTO_TCP) begin
      new_entry.cnt.tcp_pkt_cnt  = base_cnt.tcp_pkt_cnt + 64'd1;
      new_entry.cnt.tcp_byte_cnt = base_cnt.tcp_byte_cnt + {48'd0, len_r};
    end else if (proto_r == PROTO_UDP) begin
      new_entry.cnt.udp_pkt_cnt  = base_cnt.udp_pkt_cnt + 64'd1;
      new_entry.cnt.udp_byte_cnt = base_cnt.udp_byte_cnt + {48'd0, len_r};
    end
  end

  // status: a miss with the last cell in use pushes that entry out
  always_comb begin
    upd_evicted = '0;
    if (root.found) begin
      upd_status = ST_HIT;
    end else if (chain[ENTRIES].valid) begin
      upd_status  = ST_EVICT;
      upd_evicted = chain[ENTRIES].addr;
    end else begin
      upd_status = ST_NEW;
    end
  end

  assign chain[0] = new_entry;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pstc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(i)),
      .ctl        (ctl),
      .prev_entry (chain[i]),
      .entry      (chain[i + 1]),
      .hit        (hit_vec[i]),
      .leaf       (leaves[i])
    );
  end

  for (genvar i = ENTRIES; i < TREE_N; i++) begin : g_pad
    assign leaves[i] = '0;
  end

  pstc_tree u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.evicted_addr     = out_r.evicted_addr;
  assign out_ch.tcp_byte_total   = out_r.cnt.tcp_byte_cnt;
  assign out_ch.tcp_packet_total = out_r.cnt.tcp_pkt_cnt;
  assign out_ch.udp_byte_total   = out_r.cnt.udp_byte_cnt;
  assign out_ch.udp_packet_total = out_r.cnt.udp_pkt_cnt;

  // addresses in the chain are distinct, so at most one cell matches
  `PSTC_ASSERT_IMP(a_single_hit, state_r == S_TREE || state_r == S_UPD, $onehot0(hit_vec),
    "more than one cell matched the key")
  // an ignored word reports zero counters
  `PSTC_ASSERT_IMP(a_ignored_zero, out_valid_r && out_r.status == ST_IGNORED,
    out_r.cnt == '0 && out_r.evicted_addr == '0, "ignored word carries data")
  // a word taken in always leaves the idle state
  `PSTC_ASSERT_NXT(a_busy_after_accept, in_acc, state_r != S_IDLE,
    "sequencer stayed idle after taking a word")
  // the chain fills from the head, so a used last cell means all are used
  `PSTC_ASSERT_IMP(a_fill_from_head, chain[ENTRIES].valid, chain[1].valid,
    "chain has a hole at the head")
endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// checks the per-source traffic counter against an exact-lru predictor
// ---------------------------------------------------------------------------
// Header words go in through the input channel. Every accepted word is
// predicted at once into a queue of expected results. Each result word
// is compared field by field with the oldest prediction. The stimulus has
// these parts:
//   - directed words
//   - a fill run of fresh sources
//   - a random mix of hits, fresh sources and ignored words
// Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module testbench;
  import pstc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL     = 300;
  localparam int FILL_WORDS     = 200;
  localparam int RANDOM_WORDS   = 380;
  localparam int QUIET_TAIL     = 80;

  typedef struct {
    logic        header_complete;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [7:0]  ip_protocol;
    logic [15:0] ip_total_length;
  } header_t;

  // table model: recency queue of source addresses plus their counters
  class traffic_scoreboard;
    logic [31:0] recency[$];
    counters_t   counts_by_src[logic [31:0]];
    result_t     pending_results[$];
    int          errors;
    int          status_seen[4];

    function void note_header(header_t h);
      result_t   r;
      counters_t c;
      int        hits[$];
      r = '0;
      if (h.header_complete !== 1'b1 || h.ether_type != ETHERTYPE_IPV4) begin
        r.status = ST_IGNORED;
      end else begin
        hits = recency.find_first_index(a) with (a == h.src_addr);
        if (hits.size() != 0) begin
          r.status = ST_HIT;
          recency.delete(hits[0]);
          c = counts_by_src[h.src_addr];
        end else begin
          if (recency.size() < ENTRIES) begin
            r.status = ST_NEW;
          end else begin
            r.status = ST_EVICT;
            r.evicted_addr = recency.pop_back();
            counts_by_src.delete(r.evicted_addr);
          end
          c = '0;
        end
        recency.push_front(h.src_addr);
        if (h.ip_protocol == PROTO_TCP) begin
          c.tcp_pkt_cnt  = c.tcp_pkt_cnt + 64'd1;
          c.tcp_byte_cnt = c.tcp_byte_cnt + {48'd0, h.ip_total_length};
        end else if (h.ip_protocol == PROTO_UDP) begin
          c.udp_pkt_cnt  = c.udp_pkt_cnt + 64'd1;
          c.udp_byte_cnt = c.udp_byte_cnt + {48'd0, h.ip_total_length};
        end
        counts_by_src[h.src_addr] = c;
        r.cnt = c;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      status_seen[exp.status]++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.evicted_addr !== exp.evicted_addr) begin
        $error("evicted_addr: expected %h, got %h", exp.evicted_addr, got.evicted_addr);
        errors++;
      end
      if (got.cnt.tcp_byte_cnt !== exp.cnt.tcp_byte_cnt) begin
        $error("tcp_byte_total: expected %0d, got %0d",
               exp.cnt.tcp_byte_cnt, got.cnt.tcp_byte_cnt);
        errors++;
      end
      if (got.cnt.tcp_pkt_cnt !== exp.cnt.tcp_pkt_cnt) begin
        $error("tcp_packet_total: expected %0d, got %0d",
               exp.cnt.tcp_pkt_cnt, got.cnt.tcp_pkt_cnt);
        errors++;
      end
      if (got.cnt.udp_byte_cnt !== exp.cnt.udp_byte_cnt) begin
        $error("udp_byte_total: expected %0d, got %0d",
               exp.cnt.udp_byte_cnt, got.cnt.udp_byte_cnt);
        errors++;
      end
      if (got.cnt.udp_pkt_cnt !== exp.cnt.udp_pkt_cnt) begin
        $error("udp_packet_total: expected %0d, got %0d",
               exp.cnt.udp_pkt_cnt, got.cnt.udp_pkt_cnt);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pstc_in_if  in_ch ();
  pstc_out_if out_ch ();

  per_source_protocol_traffic_counter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  traffic_scoreboard sb = new();

  bit quiet_tail;
  int results_seen;
  int idle_cycles;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- sender side ----

  // offer one header word and hold it until the block takes it
  task automatic send_header(header_t h);
    in_ch.header_complete <= h.header_complete;
    in_ch.ether_type      <= h.ether_type;
    in_ch.src_addr        <= h.src_addr;
    in_ch.ip_protocol     <= h.ip_protocol;
    in_ch.ip_total_length <= h.ip_total_length;
    in_ch.valid           <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_header(h);
  endtask

  // random gap between words, never in the quiet tail
  task automatic sender_gap();
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic header_t ipv4_word(logic [31:0] src, logic [7:0] proto,
                                        logic [15:0] len);
    header_t h;
    h.header_complete = 1'b1;
    h.ether_type      = ETHERTYPE_IPV4;
    h.src_addr        = src;
    h.ip_protocol     = proto;
    h.ip_total_length = len;
    return h;
  endfunction

  // mostly tcp and udp, sometimes any protocol number
  function automatic logic [7:0] pick_protocol();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PROTO_TCP;
    if (r < 8) return PROTO_UDP;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hffff;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic run_directed();
    header_t h;
    // ignored words: incomplete header, wrong ether type, both
    h = ipv4_word(32'h0a000001, PROTO_TCP, 16'd100);
    h.header_complete = 1'b0;
    send_header(h);
    h = ipv4_word(32'h0a000001, PROTO_TCP, 16'd100);
    h.ether_type = 16'h86dd;
    send_header(h);
    h.ether_type = 16'hffff;
    send_header(h);
    h.ether_type = 16'h0000;
    h.header_complete = 1'b0;
    send_header(h);
    h.ether_type = 16'h0801;
    h.header_complete = 1'b1;
    send_header(h);
    // first entries, extremes of address and length
    send_header(ipv4_word(32'h00000000, PROTO_TCP, 16'd0));
    send_header(ipv4_word(32'h00000000, PROTO_TCP, 16'hffff));
    send_header(ipv4_word(32'h00000000, PROTO_UDP, 16'hffff));
    send_header(ipv4_word(32'h00000000, PROTO_UDP, 16'd0));
    sender_gap();
    // other protocols create or touch an entry without counting, then udp and tcp count
    send_header(ipv4_word(32'hffffffff, 8'd0, 16'hffff));
    send_header(ipv4_word(32'hffffffff, 8'hff, 16'd1234));
    send_header(ipv4_word(32'hffffffff, PROTO_UDP, 16'd60));
    send_header(ipv4_word(32'h0a000001, 8'd1, 16'd84));
    send_header(ipv4_word(32'h0a000001, PROTO_TCP, 16'd1500));
    sender_gap();
    // hits on older entries reorder recency
    send_header(ipv4_word(32'h00000000, PROTO_TCP, 16'd40));
    send_header(ipv4_word(32'hffffffff, PROTO_TCP, 16'd52));
    send_header(ipv4_word(32'h0a000001, PROTO_UDP, 16'd576));
    // ignored word between valid ones leaves the table alone
    h = ipv4_word(32'h00000000, PROTO_TCP, 16'd9);
    h.header_complete = 1'b0;
    send_header(h);
    send_header(ipv4_word(32'h00000000, PROTO_TCP, 16'd9));
  endtask

  // fresh sources to populate the table
  task automatic run_fill();
    repeat (FILL_WORDS) begin
      send_header(ipv4_word($urandom(), pick_protocol(), pick_length()));
      sender_gap();
    end
  endtask

  task automatic run_random();
    header_t h;
    int      kind;
    int      n;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS - QUIET_TAIL) quiet_tail = 1'b1;
      // one pause with nothing in flight
      if (i == RANDOM_WORDS / 2) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
      end
      n = sb.recency.size();
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        // hit on a recently used source
        h = ipv4_word(sb.recency[$urandom_range(0, (n < 32 ? n : 32) - 1)],
                      pick_protocol(), pick_length());
      end else if (kind < 10) begin
        // hit on one of the oldest sources
        h = ipv4_word(sb.recency[n - 1 - $urandom_range(0, 3)],
                      pick_protocol(), pick_length());
      end else if (kind < 12) begin
        // hit anywhere in the table
        h = ipv4_word(sb.recency[$urandom_range(0, n - 1)],
                      pick_protocol(), pick_length());
      end else if (kind < 17) begin
        // new source
        h = ipv4_word($urandom(), pick_protocol(), pick_length());
      end else begin
        // noise: broken header or random ether type, sometimes a valid ipv4 word
        h.header_complete = 1'($urandom_range(0, 1));
        h.ether_type      = 16'($urandom_range(0, 65535));
        h.src_addr        = $urandom();
        h.ip_protocol     = 8'($urandom_range(0, 255));
        h.ip_total_length = 16'($urandom_range(0, 65535));
        if (h.header_complete && $urandom_range(0, 1)) h.ether_type = ETHERTYPE_IPV4;
      end
      send_header(h);
      sender_gap();
    end
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.header_complete <= 1'b0;
    in_ch.ether_type      <= '0;
    in_ch.src_addr        <= '0;
    in_ch.ip_protocol     <= '0;
    in_ch.ip_total_length <= '0;
    quiet_tail            = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_fill();
    run_random();
    in_ch.valid <= 1'b0;
    // drain, then let the pipeline settle
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("covered %0d results: %0d ignored, %0d hits, %0d new, %0d evictions",
             results_seen, sb.status_seen[ST_IGNORED], sb.status_seen[ST_HIT],
             sb.status_seen[ST_NEW], sb.status_seen[ST_EVICT]);
    $display("table held %0d sources at the end, with long and short stalls",
             sb.recency.size());
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // ---- receiver side ----

  initial begin
    bit long_stall_done;
    long_stall_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n === 1'b1);
    forever begin
      if (quiet_tail) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!long_stall_done && results_seen >= 150) begin
        // long hold-off while the sender keeps offering, input must stall
        long_stall_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status           = out_ch.status;
      got.evicted_addr     = out_ch.evicted_addr;
      got.cnt.tcp_byte_cnt = out_ch.tcp_byte_total;
      got.cnt.tcp_pkt_cnt  = out_ch.tcp_packet_total;
      got.cnt.udp_byte_cnt = out_ch.udp_byte_total;
      got.cnt.udp_pkt_cnt  = out_ch.udp_packet_total;
      results_seen++;
      sb.check_result(got);
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
